// ===== rtl/spr_pkg.sv =====
`default_nettype none

package spr_pkg;

  localparam int WEIGHT_W = 16;
  localparam int DITHER_W = 16;
  localparam int SLOT_W   = 6;
  localparam int PSUM_W   = 22;
  localparam int SQSUM_W  = 38;
  localparam int NCNT_W   = 7;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_EFFECTIVE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESAMPLE_ENABLE = 1'b1;

  localparam logic [NCNT_W-1:0] MIN_EFFECTIVE_RST = 7'd48;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [DITHER_W-1:0] dither;
    logic                last;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] keep_index;
    logic              apply;
    logic              end_of_list;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/stratified_particle_resampler_top.sv =====
`default_nettype none

// Stratified particle resampler. Particles arrive one per transaction (weight, dither, last)
// and are taken at one per cycle while in the load state; a set ends on last or when
// MAX_PARTICLES particles have been loaded. Running totals are kept in registers, while the
// prefix sums and dithers sit in two simple dual-port synchronous memories. After the set
// ends, states SQ1, SQ2 and SQ3 compute the apply flag (wt^2 < min_effective * sum of squares,
// with split partial products), then a two-pointer walk over the memories emits one result
// per slot: each walk step passes through memory read, products and compare, and a set of N
// particles needs at most 2N-1 steps; output stalls hold it in compare. The next set may start
// loading while the final result of a run still waits to be taken. An all-zero weight set
// yields keep_index equal to slot with apply low. Configuration writes take effect at once.
module stratified_particle_resampler_top
  import spr_pkg::*;
#(
  parameter int MAX_PARTICLES = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAX_PARTICLES - 1);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_SQ1  = 3'd1;
  localparam logic [2:0] S_SQ2  = 3'd2;
  localparam logic [2:0] S_SQ3  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_CMP  = 3'd6;

  logic [PSUM_W-1:0]   prefix_mem [MAX_PARTICLES];
  logic [DITHER_W-1:0] dither_mem [MAX_PARTICLES];

  logic [2:0]          state_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [PSUM_W-1:0]   wt_r;
  logic [SQSUM_W-1:0]  sq_r;
  logic [NCNT_W-1:0]   min_eff_r;
  logic                enable_r;
  logic [IDX_W-1:0]    i_r;
  logic [IDX_W-1:0]    c_r;
  logic                apply_r;
  logic [PSUM_W-1:0]   psum_q_r;
  logic [DITHER_W-1:0] dither_q_r;
  logic [2*PSUM_W-1:0] wsq_r;
  logic [25:0]         msq_lo_r;
  logic [25:0]         msq_hi_r;
  logic [PSUM_W+NCNT_W-1:0] lhs_r;
  logic [2*PSUM_W-1:0] rhs_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic                in_fire;
  logic                set_end;
  logic [2*WEIGHT_W-1:0] wsq_in;
  logic [PSUM_W-1:0]   wt_nxt;
  logic [SQSUM_W-1:0]  sq_nxt;
  logic [2*PSUM_W:0]   msq;
  logic                lhs_gt;
  logic                step_i;
  logic                out_free;
  logic                last_slot;
  logic                emit;

  assign in_ready  = (state_r == S_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign set_end   = in_data.last || (cnt_r == LAST_IDX);
  assign wsq_in    = in_data.weight * in_data.weight;
  assign wt_nxt    = wt_r + PSUM_W'(in_data.weight);
  assign sq_nxt    = sq_r + SQSUM_W'(wsq_in);
  assign msq       = {msq_hi_r, 19'd0} + (2*PSUM_W+1)'(msq_lo_r);
  assign lhs_gt    = {lhs_r, 16'd0} > {1'b0, rhs_r};
  assign step_i    = (wt_r != '0) && ((CNT_W'(i_r) + 1'b1) < cnt_r) && !lhs_gt;
  assign out_free  = !out_valid_r || out_ready;
  assign last_slot = (CNT_W'(c_r) + 1'b1) == cnt_r;
  assign emit      = (state_r == S_CMP) && !step_i && out_free;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      prefix_mem[cnt_r[IDX_W-1:0]] <= wt_nxt;
      dither_mem[cnt_r[IDX_W-1:0]] <= in_data.dither;
    end
    psum_q_r   <= prefix_mem[i_r];
    dither_q_r <= dither_mem[c_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_eff_r <= MIN_EFFECTIVE_RST;
      enable_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_EFFECTIVE:   min_eff_r <= cfg_wdata;
        REG_RESAMPLE_ENABLE: enable_r  <= cfg_wdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    wsq_r    <= wt_r * wt_r;
    msq_lo_r <= min_eff_r * sq_r[18:0];
    msq_hi_r <= min_eff_r * sq_r[SQSUM_W-1:19];
    lhs_r    <= psum_q_r * NCNT_W'(cnt_r);
    rhs_r    <= {SLOT_W'(c_r), dither_q_r} * wt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      wt_r        <= '0;
      sq_r        <= '0;
      i_r         <= '0;
      c_r         <= '0;
      apply_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit || (out_valid_r && !out_ready);
      unique case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            wt_r  <= wt_nxt;
            sq_r  <= sq_nxt;
            cnt_r <= cnt_r + 1'b1;
            if (set_end) begin
              state_r <= S_SQ1;
            end
          end
        end
        S_SQ1: state_r <= S_SQ2;
        S_SQ2: state_r <= S_SQ3;
        S_SQ3: begin
          apply_r <= enable_r && (wt_r != '0) && ({1'b0, wsq_r} < msq);
          i_r     <= '0;
          c_r     <= '0;
          state_r <= S_RD;
        end
        S_RD:  state_r <= S_MUL;
        S_MUL: state_r <= S_CMP;
        S_CMP: begin
          if (step_i) begin
            i_r     <= i_r + 1'b1;
            state_r <= S_RD;
          end else if (out_free) begin
            out_data_r.slot        <= SLOT_W'(c_r);
            out_data_r.keep_index  <= (wt_r == '0) ? SLOT_W'(c_r) : SLOT_W'(i_r);
            out_data_r.apply       <= apply_r;
            out_data_r.end_of_list <= last_slot;
            if (last_slot) begin
              wt_r    <= '0;
              sq_r    <= '0;
              cnt_r   <= '0;
              state_r <= S_LOAD;
            end else begin
              c_r     <= c_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_load_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> (cnt_r <= LAST_IDX))
    else $error("load count past store depth");

  a_walk_index_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ((CNT_W'(i_r) < cnt_r) && (CNT_W'(c_r) < cnt_r)))
    else $error("walk pointer outside loaded set");

  a_run_clears_totals: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CMP) && !step_i && out_free && last_slot)
      |=> ((cnt_r == '0) && (wt_r == '0) && (sq_r == '0) && out_valid_r))
    else $error("totals not cleared after final slot");

  a_no_emit_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CMP) && step_i && !out_valid_r) |=> !out_valid_r)
    else $error("result emitted while source pointer advances");

endmodule

`default_nettype wire
